FILE: rtl/core/aabb_overlap_pushout_top_defines.svh
// ----------------------------------------------------------------------------
// aabb_overlap_pushout_top_defines.svh
// Assertion macros for the box overlap push-out block.
// ----------------------------------------------------------------------------
`ifndef AABB_OVERLAP_PUSHOUT_TOP_DEFINES_SVH
`define AABB_OVERLAP_PUSHOUT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// plain condition checked at every edge out of reset
`define AOP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("aop assertion failed");
// same-cycle implication
`define AOP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aop implication failed");
// next-cycle implication
`define AOP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aop next-cycle check failed");
`else
`define AOP_ASSERT(lbl, cond)
`define AOP_ASSERT_IMP(lbl, ante, cons)
`define AOP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/aop_pkg.sv
// ----------------------------------------------------------------------------
// aop_pkg
// Shared types, constants and helpers of the box overlap push-out block.
// ----------------------------------------------------------------------------
package aop_pkg;

  localparam logic signed [15:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [15:0] POS_MIN = 16'sh8000;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // trial codes, in search order
  localparam logic [2:0] PH_POS_X = 3'd0;
  localparam logic [2:0] PH_NEG_X = 3'd1;
  localparam logic [2:0] PH_POS_Z = 3'd2;
  localparam logic [2:0] PH_NEG_Z = 3'd3;
  localparam logic [2:0] PH_POS_Y = 3'd4;
  localparam logic [2:0] PH_NEG_Y = 3'd5;

  // configuration register indexes
  localparam logic CFG_STEP_SIZE   = 1'b0;
  localparam logic CFG_ROUND_LIMIT = 1'b1;

  localparam logic [11:0] STEP_SIZE_RST   = 12'd26;
  localparam logic [7:0]  ROUND_LIMIT_RST = 8'd64;

  typedef struct packed {
    logic [5:0]         pad;
    logic [14:0]        b_size_z;
    logic [14:0]        b_size_y;
    logic [14:0]        b_size_x;
    logic signed [15:0] b_z;
    logic signed [15:0] b_y;
    logic signed [15:0] b_x;
    logic [14:0]        a_size_z;
    logic [14:0]        a_size_y;
    logic [14:0]        a_size_x;
    logic signed [15:0] a_z;
    logic signed [15:0] a_y;
    logic signed [15:0] a_x;
  } in_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic signed [15:0] new_z;
    logic signed [15:0] new_y;
    logic signed [15:0] new_x;
    logic               gave_up;
    logic               hit;
  } out_t;

  typedef struct packed {
    logic               ovl;
    logic signed [15:0] pos;
  } lane_res_t;

  typedef struct packed {
    logic ovl;      // all axes overlap at the tried position
    logic cleared;  // trial moved A clear of B
    logic exhaust;  // last trial of last round failed
  } merge_t;

  function automatic logic [1:0] phase_axis(input logic [2:0] ph);
    logic [1:0] ax;
    case (ph) inside
      PH_POS_X, PH_NEG_X: ax = AXIS_X;
      PH_POS_Z, PH_NEG_Z: ax = AXIS_Z;
      default:            ax = AXIS_Y;
    endcase
    return ax;
  endfunction

endpackage

FILE: rtl/core/aop_lane.sv
// ----------------------------------------------------------------------------
// aop_lane
// One axis: optional saturated move of A's centre, then the interval test.
// ----------------------------------------------------------------------------
module aop_lane import aop_pkg::*; (
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  input  logic [14:0]        hsum,
  input  logic [19:0]        amt,
  input  logic               move,
  input  logic               neg,
  output lane_res_t          res
);

  logic signed [20:0] a_ext;
  logic signed [20:0] amt_ext;
  logic signed [20:0] sum;
  logic signed [15:0] cand;
  logic signed [16:0] diff;
  logic [16:0]        abs_diff;

  always_comb begin
    a_ext   = 21'(a);
    amt_ext = $signed({1'b0, amt});
    sum     = neg ? (a_ext - amt_ext) : (a_ext + amt_ext);
    if (!move) begin
      cand = a;
    end else if (sum > 21'sd32767) begin
      cand = POS_MAX;
    end else if (sum < -21'sd32768) begin
      cand = POS_MIN;
    end else begin
      cand = sum[15:0];
    end
    // apart only when centre distance exceeds the summed half extents
    diff     = 17'(cand) - 17'(b);
    abs_diff = diff[16] ? $unsigned(-diff) : $unsigned(diff);
    res.ovl  = (abs_diff <= {2'b00, hsum});
    res.pos  = cand;
  end

endmodule

FILE: rtl/core/aop_merge.sv
// ----------------------------------------------------------------------------
// aop_merge
// Combines the three lane tests into the trial verdict.
// ----------------------------------------------------------------------------
module aop_merge import aop_pkg::*; (
  input  logic [2:0] lane_ovl,
  input  logic       trial,
  input  logic [2:0] phase,
  input  logic [7:0] round,
  input  logic [7:0] round_limit,
  output merge_t     verdict
);

  always_comb begin
    verdict.ovl     = &lane_ovl;
    verdict.cleared = trial && !verdict.ovl;
    verdict.exhaust = trial && verdict.ovl && (phase == PH_NEG_Y) && (round == round_limit);
  end

endmodule

FILE: rtl/core/aabb_overlap_pushout_top.sv
// ----------------------------------------------------------------------------
// aabb_overlap_pushout_top
// Overlap test and push-out of two axis-aligned boxes, Q8.8 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transaction carries both boxes (centres and full
//   extents). Output stream (m_*): one transaction per input with hit,
//   gave_up and A's resolved centre. Config: cfg_we/cfg_index/cfg_data write
//   step_size (index 0) or round_limit (index 1); the user must write them
//   only while the block idles, which the block itself does not enforce.
//   Sequence: the accepting edge enters the test state for the first test;
//   if A overlaps B and round_limit is nonzero, the trial state then runs
//   the trials until one clears or the rounds run out; the finish state
//   loads the output register once it is free. A new item is taken only
//   after the last one has left the finish state; the three axis lanes test
//   one trial per cycle and the sequencer walks the six moves of each round.
//   The amount grows by step_size each round through an adder, no multiply.
//   Reset clears the sequencer and output valid and loads the register
//   defaults (step 26, limit 64). A stalled receiver holds the result in the
//   output register; the next item is still accepted and searched, and
//   waits for the output register before it is delivered.
// ----------------------------------------------------------------------------
`include "aabb_overlap_pushout_top_defines.svh"

module aabb_overlap_pushout_top import aop_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_x, a_y, a_z, a_size_x, a_size_y, a_size_z,
  // b_x, b_y, b_z, b_size_x, b_size_y, b_size_z, zero pad
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit, gave_up, new_x, new_y, new_z, zero pad
  output logic [55:0]  m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [11:0]  cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_TEST   = 2'd1;
  localparam logic [1:0] ST_TRIAL  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]  state;
  logic [11:0] step_size;
  logic [7:0]  round_limit;

  // working item
  logic signed [15:0] orig [3];
  logic signed [15:0] bpos [3];
  logic [14:0]        hsum [3];
  logic signed [15:0] res_pos [3];
  logic [19:0] amt;
  logic [7:0]  round;
  logic [2:0]  phase;
  logic        hit;
  logic        gave_up;
  out_t        out_r;

  in_t         in_w;
  lane_res_t   lane [3];
  logic [2:0]  lane_ovl;
  merge_t      verdict;
  logic        trial;
  logic        out_free;

  assign in_w     = in_t'(s_tdata);
  assign s_tready = (state == ST_IDLE);
  assign trial    = (state == ST_TRIAL);
  assign out_free = !m_tvalid || m_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= STEP_SIZE_RST;
      round_limit <= ROUND_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:   step_size   <= cfg_data;
        CFG_ROUND_LIMIT: round_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // axis lanes; only the axis of the current trial moves
  for (genvar i = 0; i < 3; i++) begin : g_lane
    aop_lane u_lane (
      .a    (orig[i]),
      .b    (bpos[i]),
      .hsum (hsum[i]),
      .amt  (amt),
      .move (trial && (phase_axis(phase) == 2'(i))),
      .neg  (phase[0]),
      .res  (lane[i])
    );
    assign lane_ovl[i] = lane[i].ovl;
  end

  aop_merge u_merge (
    .lane_ovl    (lane_ovl),
    .trial       (trial),
    .phase       (phase),
    .round       (round),
    .round_limit (round_limit),
    .verdict     (verdict)
  );

  // trial sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (verdict.ovl && (round_limit != 8'd0)) begin
            state <= ST_TRIAL;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_TRIAL: begin
          if (verdict.cleared || verdict.exhaust) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          orig[0] <= in_w.a_x;
          orig[1] <= in_w.a_y;
          orig[2] <= in_w.a_z;
          bpos[0] <= in_w.b_x;
          bpos[1] <= in_w.b_y;
          bpos[2] <= in_w.b_z;
          hsum[0] <= {1'b0, in_w.a_size_x[14:1]} + {1'b0, in_w.b_size_x[14:1]};
          hsum[1] <= {1'b0, in_w.a_size_y[14:1]} + {1'b0, in_w.b_size_y[14:1]};
          hsum[2] <= {1'b0, in_w.a_size_z[14:1]} + {1'b0, in_w.b_size_z[14:1]};
        end
      end
      ST_TEST: begin
        hit      <= verdict.ovl;
        gave_up  <= verdict.ovl && (round_limit == 8'd0);
        res_pos  <= orig;
        amt      <= {8'd0, step_size};
        round    <= 8'd1;
        phase    <= PH_POS_X;
      end
      ST_TRIAL: begin
        if (verdict.cleared) begin
          gave_up    <= 1'b0;
          res_pos[0] <= lane[0].pos;
          res_pos[1] <= lane[1].pos;
          res_pos[2] <= lane[2].pos;
        end else if (verdict.exhaust) begin
          gave_up <= 1'b1;
        end else if (phase == PH_NEG_Y) begin
          // next round: amount = round * step
          round <= round + 8'd1;
          amt   <= amt + {8'd0, step_size};
          phase <= PH_POS_X;
        end else begin
          phase <= phase + 3'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_r.pad     <= '0;
      out_r.hit     <= hit;
      out_r.gave_up <= gave_up;
      out_r.new_x   <= res_pos[0];
      out_r.new_y   <= res_pos[1];
      out_r.new_z   <= res_pos[2];
    end
  end

  assign m_tdata = out_r;

  `AOP_ASSERT_IMP(a_round_range, trial, (round != 8'd0) && (round <= round_limit))
  `AOP_ASSERT_IMP(a_phase_range, trial, phase <= PH_NEG_Y)
  `AOP_ASSERT_IMP(a_gave_up_hit, m_tvalid, !out_r.gave_up || out_r.hit)
  `AOP_ASSERT_NXT(a_accept_test, s_tvalid && s_tready, state == ST_TEST)

endmodule
